### rtl/pidspd_pkg.sv
package pidspd_pkg;

    localparam int SPEED_W = 16;
    localparam int ERR_W   = SPEED_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int SUM_W   = 32;
    localparam int GAIN_W  = 20;
    localparam int LIMIT_W = 15;
    localparam int DRIVE_W = 16;
    localparam int FRAC_W  = 8;

    // Widest product: 21-bit signed gain times the 32-bit error sum.
    localparam int WIDE_W  = GAIN_W + 1 + SUM_W;
    localparam int P_PROD_W = GAIN_W + 1 + ERR_W;
    localparam int I_PROD_W = GAIN_W + 1 + SUM_W;
    localparam int D_PROD_W = GAIN_W + 1 + DIFF_W;
    localparam int TOTAL_W  = DRIVE_W + 2;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = GAIN_W;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 20'd21760;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 20'd0;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 20'd2560;
    localparam logic [LIMIT_W-1:0] PROP_LIMIT_RST  = 15'd5000;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 15'd0;
    localparam logic [LIMIT_W-1:0] DERIV_LIMIT_RST = 15'd1000;
    localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd7000;

    localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN   = 3'd0,
        REG_INTEG_GAIN  = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_PROP_LIMIT  = 3'd3,
        REG_INTEG_LIMIT = 3'd4,
        REG_DERIV_LIMIT = 3'd5,
        REG_DRIVE_LIMIT = 3'd6
    } cfg_reg_t;

    // Symmetric clamp of a wide signed value to +/- lim.
    function automatic logic signed [DRIVE_W-1:0] clamp_sym(
        input logic signed [WIDE_W-1:0] v,
        input logic [LIMIT_W-1:0]       lim
    );
        logic signed [WIDE_W-1:0]  l;
        logic signed [DRIVE_W-1:0] l16;
        l   = $signed(WIDE_W'(lim));
        l16 = $signed({1'b0, lim});
        if (v > l) begin
            return l16;
        end else if (v < -l) begin
            return -l16;
        end else begin
            return v[DRIVE_W-1:0];
        end
    endfunction

endpackage

### rtl/pid_speed_loop_clamped_top.sv
// Clamped PID speed loop.
// Input stream (s_*): one beat per control tick, target and measured speed.
// Output stream (m_*): one beat per input beat, the clamped drive command.
// Configuration channel (cfg_*): writes gains and limits by register index;
// cfg_ready is always high and writes to unused indexes are dropped. Write
// configuration only while no beat is in flight.
// The datapath is a four-register pipeline: input register, error/sum stage
// (the loop state lives here), product stage with the three multipliers, and
// the clamp/sum output register. An accepted beat moves through them to m_*.
// Throughput is one beat per cycle unless stalled; the error-sum recurrence
// is a single saturating add, so consecutive ticks follow back to back.
// Each stage holds its beat while the next is full, so a stalled receiver
// fills the bubbles first; s_tready falls only once all four stages are full.
// Reset clears the error sum, the previous error, all valid flags and loads
// the default gains and limits.
module pid_speed_loop_clamped_top
    import pidspd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [2*SPEED_W-1:0]   s_tdata,    // [15:0] target_speed, [31:16] measured_speed

    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [DRIVE_W-1:0]     m_tdata,    // [15:0] drive

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [GAIN_W-1:0]  prop_gain_reg, integ_gain_reg, deriv_gain_reg;
    logic [LIMIT_W-1:0] prop_limit_reg, integ_limit_reg, deriv_limit_reg, drive_limit_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic rdy0, rdy1, rdy2, rdy3;

    logic signed [SPEED_W-1:0] target_reg, measured_reg;

    logic signed [ERR_W-1:0]  prev_err_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W:0]    sum_wide;

    logic signed [ERR_W-1:0]  err1_reg;
    logic signed [SUM_W-1:0]  sum1_reg;
    logic signed [DIFF_W-1:0] diff1_reg;

    logic signed [P_PROD_W-1:0] p_prod_reg;
    logic signed [I_PROD_W-1:0] i_prod_reg;
    logic signed [D_PROD_W-1:0] d_prod_reg;

    logic signed [P_PROD_W-1:0] p_shift;
    logic signed [I_PROD_W-1:0] i_shift;
    logic signed [D_PROD_W-1:0] d_shift;
    logic signed [DRIVE_W-1:0]  p_term, i_term, d_term;
    logic signed [TOTAL_W-1:0]  total;
    logic signed [DRIVE_W-1:0]  drive_reg;

    logic state_upd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            prop_limit_reg  <= PROP_LIMIT_RST;
            integ_limit_reg <= INTEG_LIMIT_RST;
            deriv_limit_reg <= DERIV_LIMIT_RST;
            drive_limit_reg <= DRIVE_LIMIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_data;
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_data;
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_data;
                REG_PROP_LIMIT:  prop_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_DERIV_LIMIT: deriv_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_DRIVE_LIMIT: drive_limit_reg <= cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or its beat moves on this cycle.
    assign rdy3     = !v3_reg || m_tready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0;

    assign state_upd = v0_reg && rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy0) v0_reg <= s_tvalid;
            if (rdy1) v1_reg <= v0_reg;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy0 && s_tvalid) begin
            target_reg   <= $signed(s_tdata[SPEED_W-1:0]);
            measured_reg <= $signed(s_tdata[2*SPEED_W-1:SPEED_W]);
        end
    end

    // Error, saturating error sum and error difference.
    always_comb begin
        err      = ERR_W'(target_reg) - ERR_W'(measured_reg);
        diff     = DIFF_W'(err) - DIFF_W'(prev_err_reg);
        sum_wide = (SUM_W+1)'(sum_reg) + (SUM_W+1)'(err);
        if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg      <= '0;
            prev_err_reg <= '0;
        end else if (state_upd) begin
            sum_reg      <= sum_next;
            prev_err_reg <= err;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_upd) begin
            err1_reg  <= err;
            sum1_reg  <= sum_next;
            diff1_reg <= diff;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && rdy2) begin
            p_prod_reg <= $signed({1'b0, prop_gain_reg}) * err1_reg;
            i_prod_reg <= $signed({1'b0, integ_gain_reg}) * sum1_reg;
            d_prod_reg <= $signed({1'b0, deriv_gain_reg}) * diff1_reg;
        end
    end

    // Arithmetic shift rounds toward minus infinity, as required.
    always_comb begin
        p_shift = p_prod_reg >>> FRAC_W;
        i_shift = i_prod_reg >>> FRAC_W;
        d_shift = d_prod_reg >>> FRAC_W;
        p_term  = clamp_sym(WIDE_W'(p_shift), prop_limit_reg);
        i_term  = clamp_sym(WIDE_W'(i_shift), integ_limit_reg);
        d_term  = clamp_sym(WIDE_W'(d_shift), deriv_limit_reg);
        total   = TOTAL_W'(p_term) + TOTAL_W'(i_term) + TOTAL_W'(d_term);
    end

    always_ff @(posedge aclk) begin
        if (v2_reg && rdy3) begin
            drive_reg <= clamp_sym(WIDE_W'(total), drive_limit_reg);
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = drive_reg;

    // Input backpressure only when every stage holds a beat.
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (v0_reg && v1_reg && v2_reg && v3_reg && !m_tready))
        else $error("input stalled while the pipeline has a bubble");

    // The error sum must never wrap across the sign boundary.
    a_sum_no_wrap_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_upd && !err[ERR_W-1] && !sum_reg[SUM_W-1]) |=>
        (sum_reg >= $past(sum_reg)))
        else $error("error sum wrapped on a positive error");

    a_sum_no_wrap_dn: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_upd && err[ERR_W-1] && sum_reg[SUM_W-1]) |=>
        (sum_reg <= $past(sum_reg)))
        else $error("error sum wrapped on a negative error");

    // The stored previous error follows the beat that left the first stage.
    a_prev_err: assert property (@(posedge aclk) disable iff (!aresetn)
        state_upd |=> (prev_err_reg == err1_reg && sum_reg == sum1_reg))
        else $error("loop state and stage-one data disagree");

    a_reset_state: assert property (@(posedge aclk)
        !$past(aresetn) |-> (sum_reg == '0 && prev_err_reg == '0 && !m_tvalid))
        else $error("loop state not cleared by reset");

endmodule
